[rtl/ascon_pkg.sv]
// Ascon permutation package: state type, round constants and round function.
package ascon_pkg;

    localparam int TOTAL_ROUNDS = 12;
    localparam int WORD_W       = 64;
    localparam int NUM_WORDS    = 5;
    localparam int CNT_W        = 4;

    // Word k of the state sits at index k (word 0 in the lowest bits).
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] ascon_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] rounds;  // saturated round count
        ascon_state_t     st;
    } ascon_beat_t;

    function automatic logic [WORD_W-1:0] rotr64(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic ascon_state_t ascon_round(input ascon_state_t s,
                                                 input logic [CNT_W-1:0] idx);
        logic [WORD_W-1:0] a0, a1, a2, a3, a4;
        logic [WORD_W-1:0] n0, n1, n2, n3, n4;
        logic [WORD_W-1:0] rc;
        ascon_state_t      r;
        rc = {{(WORD_W-8){1'b0}}, 4'(4'd15 - idx), idx};
        // substitution layer, bitsliced
        a0 = s[0] ^ s[4];
        a4 = s[4] ^ s[3];
        a2 = s[2] ^ rc ^ s[1];
        a1 = s[1];
        a3 = s[3];
        n0 = ~a0 & a1;
        n1 = ~a1 & a2;
        n2 = ~a2 & a3;
        n3 = ~a3 & a4;
        n4 = ~a4 & a0;
        a0 = a0 ^ n1;
        a1 = a1 ^ n2;
        a2 = a2 ^ n3;
        a3 = a3 ^ n4;
        a4 = a4 ^ n0;
        a1 = a1 ^ a0;
        a0 = a0 ^ a4;
        a3 = a3 ^ a2;
        a2 = ~a2;
        // linear diffusion
        r[0] = a0 ^ rotr64(a0, 19) ^ rotr64(a0, 28);
        r[1] = a1 ^ rotr64(a1, 61) ^ rotr64(a1, 39);
        r[2] = a2 ^ rotr64(a2, 1)  ^ rotr64(a2, 6);
        r[3] = a3 ^ rotr64(a3, 10) ^ rotr64(a3, 17);
        r[4] = a4 ^ rotr64(a4, 7)  ^ rotr64(a4, 41);
        return r;
    endfunction

endpackage

[rtl/ascon_stage.sv]
// One pipeline stage of the Ascon permutation: one round, applied or bypassed, registered, with handshake.
module ascon_stage
    import ascon_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  round_idx,   // round this stage owns, tied off
    input  logic              valid_i,
    output logic              ready_o,
    input  ascon_beat_t       beat_i,
    output logic              valid_o,
    input  logic              ready_i,
    output ascon_beat_t       beat_o
);

    logic        valid_reg;
    ascon_beat_t beat_reg;
    ascon_beat_t beat_next;
    logic        active;

    // round idx runs when idx >= TOTAL_ROUNDS - rounds
    assign active = ({1'b0, beat_i.rounds} + {1'b0, round_idx}) >= (CNT_W+1)'(TOTAL_ROUNDS);

    always_comb begin
        beat_next.rounds = beat_i.rounds;
        beat_next.st     = active ? ascon_round(beat_i.st, round_idx) : beat_i.st;
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            beat_reg <= beat_next;
        end
    end

    assign valid_o = valid_reg;
    assign beat_o  = beat_reg;

endmodule

[rtl/ascon_permutation.sv]
// Ascon permutation top level: twelve-stage round pipeline with stream ports.
//
// Applies the last round_count rounds (0..12; 13..15 act as 12) of the
// twelve-round Ascon permutation to a 320-bit state of five 64-bit words,
// word 0 in the lowest bits. The core is a twelve-stage pipeline, one stage
// per round: stage i always holds round i and either applies it or passes the
// state on untouched, depending on the beat's round count. A new beat can be
// taken every cycle while m_tready is high, so sustained throughput is one
// beat per clock whatever the round count. Each beat passes through the
// twelve round registers, the last of which is the output register. Each
// stage holds its beat while the stage after it is full and stalled, so
// backpressure on m_tready ripples back to s_tready without dropping or
// repeating a beat. No reset-time sweep; the block is ready in the cycle
// after aresetn is released.
module ascon_permutation
    import ascon_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input beat
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] word0_in, [127:64] word1_in, [191:128] word2_in,
    // [255:192] word3_in, [319:256] word4_in, [323:320] round_count, [327:324] zero
    input  logic [327:0] s_tdata,
    // result beat
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] word0_out, [127:64] word1_out, [191:128] word2_out,
    // [255:192] word3_out, [319:256] word4_out
    output logic [319:0] m_tdata
);

    localparam int STATE_W = NUM_WORDS * WORD_W;

    logic        valid [0:TOTAL_ROUNDS];
    logic        ready [0:TOTAL_ROUNDS];
    ascon_beat_t beat  [0:TOTAL_ROUNDS];
    logic [CNT_W-1:0] rc_in;

    // saturate round count at twelve
    assign rc_in = (s_tdata[STATE_W +: CNT_W] > CNT_W'(TOTAL_ROUNDS))
                 ? CNT_W'(TOTAL_ROUNDS) : s_tdata[STATE_W +: CNT_W];

    assign valid[0]       = s_tvalid;
    assign s_tready       = ready[0];
    assign beat[0].rounds = rc_in;
    assign beat[0].st     = s_tdata[STATE_W-1:0];

    genvar g;
    generate
        for (g = 0; g < TOTAL_ROUNDS; g++) begin : g_round
            ascon_stage u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .round_idx (CNT_W'(g)),
                .valid_i   (valid[g]),
                .ready_o   (ready[g]),
                .beat_i    (beat[g]),
                .valid_o   (valid[g+1]),
                .ready_i   (ready[g+1]),
                .beat_o    (beat[g+1])
            );
        end
    endgenerate

    // last stage register drives the result channel directly
    assign ready[TOTAL_ROUNDS] = m_tready;
    assign m_tvalid            = valid[TOTAL_ROUNDS];
    assign m_tdata             = beat[TOTAL_ROUNDS].st;

`ifndef ASSERT_OFF
    // an empty output stage means every stage can move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // backpressure only when every stage is occupied
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid[1] && valid[2] && valid[3] && valid[4] &&
                       valid[5] && valid[6] && valid[7] && valid[8] && valid[9] &&
                       valid[10] && valid[11] && valid[12]))
        else $error("input stalled with a bubble in the pipeline");

    // a taking sink never stalls the pipeline
    a_sink_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("pipeline stalled while output is taken");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the Ascon permutation core: directed table, then random beats.
module tb;
    import ascon_pkg::*;

    // Run sizing. The limit covers the slowest legal run by a wide margin:
    // about 1820 beats, each with random idle time on either side plus the
    // trip through the 12-stage pipeline.
    localparam int N_RANDOM     = 1800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 24;
    localparam int SHOW_MAX     = 10;
    localparam int N_DIR        = 22;

    typedef logic [CNT_W-1:0] rcount_t;

    // One row of the directed table. When 'typed' is set the permuted state
    // is written into the row itself; otherwise the predictor supplies it.
    typedef struct packed {
        ascon_state_t st;
        rcount_t      rounds;
        logic         typed;
        ascon_state_t want;
    } dir_row_t;

    // Corner patterns, word 4 in the top bits
    localparam ascon_state_t ST_ZERO = '0;
    localparam ascon_state_t ST_ONES = '1;
    localparam ascon_state_t ST_ALT  = {5{64'haaaa_aaaa_5555_5555}};
    localparam ascon_state_t ST_INC  = {64'h2021_2223_2425_2627, 64'h1819_1a1b_1c1d_1e1f,
                                        64'h1011_1213_1415_1617, 64'h0809_0a0b_0c0d_0e0f,
                                        64'h0001_0203_0405_0607};
    localparam ascon_state_t ST_MSB  = {5{64'h8000_0000_0000_0000}};
    localparam ascon_state_t ST_LSB  = {5{64'h0000_0000_0000_0001}};

    // Zero rounds pass the state straight through, so those rows carry the
    // answer. Counts 13..15 must match a full twelve-round run.
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{ST_ZERO, 4'd0,  1'b1, ST_ZERO},
        '{ST_ONES, 4'd0,  1'b1, ST_ONES},
        '{ST_ALT,  4'd0,  1'b1, ST_ALT},
        '{ST_ZERO, 4'd12, 1'b0, ST_ZERO},
        '{ST_ONES, 4'd12, 1'b0, ST_ZERO},
        '{ST_ZERO, 4'd13, 1'b0, ST_ZERO},
        '{ST_ONES, 4'd14, 1'b0, ST_ZERO},
        '{ST_ALT,  4'd15, 1'b0, ST_ZERO},
        '{ST_INC,  4'd1,  1'b0, ST_ZERO},
        '{ST_INC,  4'd2,  1'b0, ST_ZERO},
        '{ST_INC,  4'd3,  1'b0, ST_ZERO},
        '{ST_INC,  4'd4,  1'b0, ST_ZERO},
        '{ST_INC,  4'd5,  1'b0, ST_ZERO},
        '{ST_INC,  4'd6,  1'b0, ST_ZERO},
        '{ST_INC,  4'd7,  1'b0, ST_ZERO},
        '{ST_INC,  4'd8,  1'b0, ST_ZERO},
        '{ST_INC,  4'd9,  1'b0, ST_ZERO},
        '{ST_INC,  4'd10, 1'b0, ST_ZERO},
        '{ST_INC,  4'd11, 1'b0, ST_ZERO},
        '{ST_MSB,  4'd12, 1'b0, ST_ZERO},
        '{ST_LSB,  4'd6,  1'b0, ST_ZERO},
        '{ST_ALT,  4'd8,  1'b0, ST_ZERO}
    };

    // Clock, reset and DUT ports; every input known from time zero
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [319:0] word0_in..word4_in (word0 lowest), [323:320] round_count, [327:324] zero
    logic [327:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [319:0] word0_out..word4_out (word0 lowest)
    logic [319:0] m_tdata;

    // Permuted states still owed by the DUT, oldest first
    ascon_state_t permuted_q [$];

    int cycles     = 0;
    int bad_beats  = 0;
    int beats_in   = 0;
    int beats_out  = 0;
    int zero_cnt   = 0;
    int sat_cnt    = 0;

    ascon_state_t got_st;
    ascon_state_t want_st;
    bit           word_bad;

    ascon_permutation i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} >> n;
        return dbl[WORD_W-1:0];
    endfunction

    // Last 'cnt' of the twelve rounds; counts above twelve clamp to twelve.
    function automatic ascon_state_t ascon_permute(input ascon_state_t s_in, input rcount_t cnt);
        logic [WORD_W-1:0] x [5];
        logic [WORD_W-1:0] y [5];
        ascon_state_t      s;
        int                first;
        int                rnd;
        int                k;
        s     = s_in;
        first = TOTAL_ROUNDS - ((cnt > TOTAL_ROUNDS) ? TOTAL_ROUNDS : int'(cnt));
        for (rnd = first; rnd < TOTAL_ROUNDS; rnd++) begin
            // round constant lands in the low byte of word 2
            s[2][7:0] = s[2][7:0] ^ {4'(15 - rnd), 4'(rnd)};
            // S-box layer, bitsliced across the 64 columns
            x[0] = s[0] ^ s[4];
            x[1] = s[1];
            x[2] = s[2] ^ s[1];
            x[3] = s[3];
            x[4] = s[4] ^ s[3];
            for (k = 0; k < 5; k++)
                y[k] = x[k] ^ (~x[(k + 1) % 5] & x[(k + 2) % 5]);
            y[1] = y[1] ^ y[0];
            y[0] = y[0] ^ y[4];
            y[3] = y[3] ^ y[2];
            y[2] = ~y[2];
            // linear layer, one rotation pair per word
            s[0] = y[0] ^ ror(y[0], 19) ^ ror(y[0], 28);
            s[1] = y[1] ^ ror(y[1], 61) ^ ror(y[1], 39);
            s[2] = y[2] ^ ror(y[2], 1)  ^ ror(y[2], 6);
            s[3] = y[3] ^ ror(y[3], 10) ^ ror(y[3], 17);
            s[4] = y[4] ^ ror(y[4], 7)  ^ ror(y[4], 41);
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Idle before the next beat; optionally hold off until the pipe is empty.
    // s_tvalid is lowered only here and after the last beat, so it never sees two NBAs in one step.
    task automatic idle_in(input int gap, input bit drain);
        if (gap > 0 || drain) begin
            s_tvalid <= 1'b0;
            if (drain)
                while (permuted_q.size() != 0) @(posedge aclk);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Present one beat and hold it until accepted; the owed result is queued
    // at the accepting edge.
    task automatic push_beat(input ascon_state_t st, input rcount_t cnt,
                             input ascon_state_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, cnt, st};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        permuted_q.push_back(want);
        beats_in++;
        if (cnt == 0)
            zero_cnt++;
        if (cnt > TOTAL_ROUNDS)
            sat_cnt++;
    endtask

    // Mostly full-random words, with all-zero and all-one words mixed in
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Bias toward the counts that real modes use (12 and 6/8), but keep the
    // full 4-bit range so that saturation is hit often.
    function automatic rcount_t rand_rounds();
        case ($urandom_range(0, 9))
            0, 1:    return 4'd12;
            2:       return 4'd6;
            3:       return 4'd8;
            default: return rcount_t'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        ascon_state_t st;
        rcount_t      cnt;
        bit           burst;
        int           gap;
        int           i;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (i = 0; i < N_DIR; i++) begin
            gap = $urandom_range(0, 9);
            idle_in(gap, 1'b0);
            push_beat(DIR_ROWS[i].st, DIR_ROWS[i].rounds,
                      DIR_ROWS[i].typed ? DIR_ROWS[i].want
                                        : ascon_permute(DIR_ROWS[i].st, DIR_ROWS[i].rounds));
        end

        // Random beats. Every 64 beats pick whether this stretch runs
        // back-to-back; the pipe is fully drained at the start and halfway.
        burst = 1'b0;
        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 9);
            idle_in(gap, (i == 0) || (i == N_RANDOM / 2));
            st  = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
            cnt = rand_rounds();
            push_beat(st, cnt, ascon_permute(st, cnt));
        end
        s_tvalid <= 1'b0;

        // Wait out the pipe, then a little longer to catch stray beats
        while (permuted_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("Checked %0d result beats: %0d directed, %0d random; %0d zero-round, %0d with count 13-15.",
                 beats_out, N_DIR, N_RANDOM, zero_cnt, sat_cnt);
        $display("Both ports idled at random, with back-to-back stretches and two full drains.");
        if (bad_beats == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls ahead of each beat, with stretches where
    // m_tready stays high throughout.
    // ------------------------------------------------------------------
    initial begin
        int  stall;
        int  n;
        bit  steady;
        n      = 0;
        steady = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (n % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            n++;
        end
    end

    // Compare each accepted result beat with the oldest owed state
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_st = m_tdata;
            if (permuted_q.size() == 0) begin
                bad_beats++;
                if (bad_beats <= SHOW_MAX)
                    $display("result beat %0d arrived with nothing owed: %h", beats_out, got_st);
            end else begin
                want_st  = permuted_q.pop_front();
                word_bad = 1'b0;
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (got_st[k] !== want_st[k]) begin
                        if (bad_beats < SHOW_MAX)
                            $display("result beat %0d word%0d_out: expected %h, got %h",
                                     beats_out, k, want_st[k], got_st[k]);
                        word_bad = 1'b1;
                    end
                end
                if (word_bad)
                    bad_beats++;
            end
            beats_out++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
